// ----- rtl/chr_pkg.sv -----
package chr_pkg;

  // ring geometry
  localparam int RING_ENTRIES = 64;
  localparam int MAX_SERVERS  = 8;
  localparam int POS_W        = 32;
  localparam int SRV_W        = 3;
  localparam int OP_W         = 2;
  localparam int STAT_W       = 2;
  localparam int CNT_W        = $clog2(RING_ENTRIES + 1);

  // reduction tree: groups of cells ORed in the first stage
  localparam int RED_GRP  = 8;
  localparam int RED_NGRP = (RING_ENTRIES + RED_GRP - 1) / RED_GRP;

  // stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((POS_W + SRV_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SRV_W + POS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } chr_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } chr_status_e;

  // action the cells take in the apply cycle
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_REM,
    ACT_OVR
  } chr_act_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_APPLY
  } chr_state_e;

  // broadcast to every cell
  typedef struct packed {
    logic                 cmp_en;
    chr_act_e             act;
    logic [POS_W-1:0]     key;
    logic [SRV_W-1:0]     srv;
  } chr_ctl_t;

  // per-cell compare result against the key
  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } chr_flag_t;

endpackage

// ----- rtl/chr_cell.sv -----
module chr_cell (
  input  logic                      clk_i,
  input  chr_pkg::chr_ctl_t         ctl_i,
  input  logic                      valid_i,
  input  logic                      prev_lt_i,
  input  logic [chr_pkg::POS_W-1:0] prev_pos_i,
  input  logic [chr_pkg::SRV_W-1:0] prev_own_i,
  input  logic [chr_pkg::POS_W-1:0] next_pos_i,
  input  logic [chr_pkg::SRV_W-1:0] next_own_i,
  output logic [chr_pkg::POS_W-1:0] pos_o,
  output logic [chr_pkg::SRV_W-1:0] own_o,
  output chr_pkg::chr_flag_t        flag_o
);

  logic [chr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [chr_pkg::SRV_W-1:0] own_q, own_d;
  chr_pkg::chr_flag_t        flag_q, flag_d;

  // compare the stored position with the key
  always_comb begin
    flag_d = flag_q;
    if (ctl_i.cmp_en) begin
      flag_d.lt = valid_i && (pos_q < ctl_i.key);
      flag_d.gt = valid_i && (pos_q > ctl_i.key);
      flag_d.eq = valid_i && (pos_q == ctl_i.key);
    end
  end

  // shift toward the tail on insert, toward the head on remove; overwrite the owner on an equal key
  always_comb begin
    pos_d = pos_q;
    own_d = own_q;
    case (ctl_i.act)
      chr_pkg::ACT_INS: begin
        if (!flag_q.lt) begin
          if (!prev_lt_i) begin
            pos_d = prev_pos_i;
            own_d = prev_own_i;
          end
          if (prev_lt_i || !valid_i && !flag_q.lt && prev_lt_i) begin
            pos_d = ctl_i.key;
            own_d = ctl_i.srv;
          end
        end
      end
      chr_pkg::ACT_REM: begin
        if (!flag_q.lt) begin
          pos_d = next_pos_i;
          own_d = next_own_i;
        end
      end
      chr_pkg::ACT_OVR: begin
        if (flag_q.eq) begin
          own_d = ctl_i.srv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    own_q  <= own_d;
    flag_q <= flag_d;
  end

  assign pos_o  = pos_q;
  assign own_o  = own_q;
  assign flag_o = flag_q;

endmodule

// ----- rtl/chr_reduce.sv -----
module chr_reduce (
  input  logic                      clk_i,
  input  logic                      sel_i [chr_pkg::RING_ENTRIES],
  input  logic                      eq_i  [chr_pkg::RING_ENTRIES],
  input  logic [chr_pkg::POS_W-1:0] pos_i [chr_pkg::RING_ENTRIES],
  input  logic [chr_pkg::SRV_W-1:0] own_i [chr_pkg::RING_ENTRIES],
  output logic                      any_sel_o,
  output logic                      any_eq_o,
  output logic [chr_pkg::POS_W-1:0] sel_pos_o,
  output logic [chr_pkg::SRV_W-1:0] sel_own_o
);

  logic                      gsel_q [chr_pkg::RED_NGRP];
  logic                      gsel_d [chr_pkg::RED_NGRP];
  logic                      geq_q  [chr_pkg::RED_NGRP];
  logic                      geq_d  [chr_pkg::RED_NGRP];
  logic [chr_pkg::POS_W-1:0] gpos_q [chr_pkg::RED_NGRP];
  logic [chr_pkg::POS_W-1:0] gpos_d [chr_pkg::RED_NGRP];
  logic [chr_pkg::SRV_W-1:0] gown_q [chr_pkg::RED_NGRP];
  logic [chr_pkg::SRV_W-1:0] gown_d [chr_pkg::RED_NGRP];

  // first stage: one-hot and-or inside each group of cells
  always_comb begin
    for (int g = 0; g < chr_pkg::RED_NGRP; g++) begin
      gsel_d[g] = 1'b0;
      geq_d[g]  = 1'b0;
      gpos_d[g] = '0;
      gown_d[g] = '0;
      for (int k = 0; k < chr_pkg::RED_GRP; k++) begin
        if (g * chr_pkg::RED_GRP + k < chr_pkg::RING_ENTRIES) begin
          geq_d[g] = geq_d[g] | eq_i[g * chr_pkg::RED_GRP + k];
          if (sel_i[g * chr_pkg::RED_GRP + k]) begin
            gsel_d[g] = 1'b1;
            gpos_d[g] = gpos_d[g] | pos_i[g * chr_pkg::RED_GRP + k];
            gown_d[g] = gown_d[g] | own_i[g * chr_pkg::RED_GRP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gsel_q <= gsel_d;
    geq_q  <= geq_d;
    gpos_q <= gpos_d;
    gown_q <= gown_d;
  end

  // second stage: combine the group results
  always_comb begin
    any_sel_o = 1'b0;
    any_eq_o  = 1'b0;
    sel_pos_o = '0;
    sel_own_o = '0;
    for (int g = 0; g < chr_pkg::RED_NGRP; g++) begin
      any_sel_o = any_sel_o | gsel_q[g];
      any_eq_o  = any_eq_o | geq_q[g];
      sel_pos_o = sel_pos_o | gpos_q[g];
      sel_own_o = sel_own_o | gown_q[g];
    end
  end

endmodule

// ----- rtl/consistent_hash_ring.sv -----
// an accepted item steps through compare in every cell, registered reduction over the
// cell row, then apply and shift the row; the result item is registered on leaving
// apply, and the next item is accepted only once the ring is back in idle
// a result waiting on the output does not block the next accept, but it stalls that item's apply
// reset: entry count cleared, ring empty; cell contents are left as they are
module consistent_hash_ring (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // ring_position [31:0], server_id [34:32], zero fill
  input  logic [chr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [chr_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // owner_server [2:0], owner_position [34:3], zero fill
  output logic [chr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [chr_pkg::STAT_W-1:0]     m_axis_tuser
);

  localparam int N = chr_pkg::RING_ENTRIES;

  chr_pkg::chr_state_e       state_q, state_d;
  logic [chr_pkg::CNT_W-1:0] count_q, count_d;
  logic [chr_pkg::OP_W-1:0]  op_q;
  logic [chr_pkg::POS_W-1:0] key_q;
  logic [chr_pkg::SRV_W-1:0] srv_q;

  logic                      out_v_q, out_v_d;
  logic [chr_pkg::SRV_W-1:0] out_srv_q, out_srv_d;
  logic [chr_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  chr_pkg::chr_status_e      out_st_q, out_st_d;

  chr_pkg::chr_ctl_t         ctl;
  logic                      accept;
  logic                      adv;

  logic                      cell_valid [N];
  logic [chr_pkg::POS_W-1:0] cell_pos   [N];
  logic [chr_pkg::SRV_W-1:0] cell_own   [N];
  chr_pkg::chr_flag_t        cell_flag  [N];
  logic                      cell_sel   [N];
  logic                      cell_eq    [N];

  logic                      any_sel;
  logic                      any_eq;
  logic [chr_pkg::POS_W-1:0] sel_pos;
  logic [chr_pkg::SRV_W-1:0] sel_own;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign adv    = (state_q == chr_pkg::S_APPLY) && (!out_v_q || m_axis_tready);

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                      prev_lt;
    logic [chr_pkg::POS_W-1:0] prev_pos;
    logic [chr_pkg::SRV_W-1:0] prev_own;
    logic [chr_pkg::POS_W-1:0] next_pos;
    logic [chr_pkg::SRV_W-1:0] next_own;

    assign cell_valid[i] = chr_pkg::CNT_W'(i) < count_q;

    // the head sees everything before it as below the key
    if (i == 0) begin : g_head
      assign prev_lt  = 1'b1;
      assign prev_pos = '0;
      assign prev_own = '0;
      assign cell_sel[i] = cell_flag[i].gt;
    end else begin : g_body
      assign prev_lt  = cell_flag[i-1].lt;
      assign prev_pos = cell_pos[i-1];
      assign prev_own = cell_own[i-1];
      assign cell_sel[i] = cell_flag[i].gt && !cell_flag[i-1].gt;
    end

    if (i == N - 1) begin : g_tail
      assign next_pos = '0;
      assign next_own = '0;
    end else begin : g_link
      assign next_pos = cell_pos[i+1];
      assign next_own = cell_own[i+1];
    end

    assign cell_eq[i] = cell_flag[i].eq;

    chr_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (cell_valid[i]),
      .prev_lt_i  (prev_lt),
      .prev_pos_i (prev_pos),
      .prev_own_i (prev_own),
      .next_pos_i (next_pos),
      .next_own_i (next_own),
      .pos_o      (cell_pos[i]),
      .own_o      (cell_own[i]),
      .flag_o     (cell_flag[i])
    );
  end

  chr_reduce u_reduce (
    .clk_i     (clk_i),
    .sel_i     (cell_sel),
    .eq_i      (cell_eq),
    .pos_i     (cell_pos),
    .own_i     (cell_own),
    .any_sel_o (any_sel),
    .any_eq_o  (any_eq),
    .sel_pos_o (sel_pos),
    .sel_own_o (sel_own)
  );

  // sequencer: next state, cell commands, result
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    out_v_d       = out_v_q && !m_axis_tready;
    out_srv_d     = out_srv_q;
    out_pos_d     = out_pos_q;
    out_st_d      = out_st_q;
    s_axis_tready = 1'b0;
    ctl.cmp_en    = 1'b0;
    ctl.act       = chr_pkg::ACT_NONE;
    ctl.key       = key_q;
    ctl.srv       = srv_q;
    case (state_q)
      chr_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = chr_pkg::S_CMP;
        end
      end
      chr_pkg::S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_d    = chr_pkg::S_RED;
      end
      chr_pkg::S_RED: begin
        state_d = chr_pkg::S_APPLY;
      end
      chr_pkg::S_APPLY: begin
        if (adv) begin
          state_d   = chr_pkg::S_IDLE;
          out_v_d   = 1'b1;
          out_srv_d = '0;
          out_pos_d = '0;
          out_st_d  = chr_pkg::ST_OK;
          case (op_q)
            chr_pkg::OP_LOOKUP: begin
              if (count_q == '0) begin
                out_st_d = chr_pkg::ST_EMPTY;
              end else if (any_sel) begin
                out_srv_d = sel_own;
                out_pos_d = sel_pos;
              end else begin
                out_srv_d = cell_own[0];
                out_pos_d = cell_pos[0];
              end
            end
            chr_pkg::OP_INSERT: begin
              if ({1'b0, srv_q} < (chr_pkg::SRV_W + 1)'(chr_pkg::MAX_SERVERS)) begin
                if (any_eq) begin
                  ctl.act = chr_pkg::ACT_OVR;
                end else if (count_q == chr_pkg::CNT_W'(N)) begin
                  out_st_d = chr_pkg::ST_FULL;
                end else begin
                  ctl.act = chr_pkg::ACT_INS;
                  count_d = count_q + chr_pkg::CNT_W'(1);
                end
              end
            end
            chr_pkg::OP_REMOVE: begin
              if (any_eq) begin
                ctl.act = chr_pkg::ACT_REM;
                count_d = count_q - chr_pkg::CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = chr_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chr_pkg::S_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  // captured item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[chr_pkg::POS_W-1:0];
      srv_q <= s_axis_tdata[chr_pkg::POS_W +: chr_pkg::SRV_W];
    end
    out_srv_q <= out_srv_d;
    out_pos_q <= out_pos_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = chr_pkg::OUT_DATA_W'({out_pos_q, out_srv_q});
  assign m_axis_tuser  = out_st_q;

  // ring never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= chr_pkg::CNT_W'(N))
    else $error("entry count above ring capacity");

  // the entry count moves only in the apply cycle, and by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q) == chr_pkg::S_APPLY &&
      (count_q == $past(count_q) + chr_pkg::CNT_W'(1) ||
       count_q == $past(count_q) - chr_pkg::CNT_W'(1)))
    else $error("entry count changed outside apply");

  // an empty-ring result carries no owner
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == chr_pkg::ST_EMPTY |-> m_axis_tdata == '0)
    else $error("empty-ring result with owner data");

  // a full-table result only when the ring is full
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) && out_st_q == chr_pkg::ST_FULL |-> count_q == chr_pkg::CNT_W'(N))
    else $error("table full reported below capacity");

endmodule
